// ===== src/rbs_pkg.sv =====
// Shared types and constants for the ray/box slab intersection block.
// No dependencies; imported by every other file in src.
package rbs_pkg;

    localparam int unsigned COORD_W = 32;  // Q16.16 input coordinate
    localparam int unsigned DIFF_W  = 33;  // corner - origin, exact
    localparam int unsigned FRAC_W  = 16;  // fraction bits of Q16.16
    localparam int unsigned NUM_W   = 48;  // |diff| << 16, divider numerator
    localparam int unsigned DEN_W   = 32;  // |dir|, divider denominator
    localparam int unsigned T_W     = 49;  // signed plane distance
    localparam int unsigned ENTRY_W = 31;  // saturated entry distance
    localparam int unsigned NAXES   = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_min_z;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic signed [COORD_W-1:0] box_max_z;
    } t_ray_req;

    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] entry_distance;
    } t_ray_rsp;

endpackage

// ===== src/rbs_udiv.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on rbs_pkg for widths.
module rbs_udiv (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rbs_pkg::NUM_W-1:0]  i_num,
    input  logic [rbs_pkg::DEN_W-1:0]  i_den,
    input  logic                       i_neg,
    output logic [rbs_pkg::NUM_W-1:0]  o_quot,
    output logic                       o_neg
);
    import rbs_pkg::*;

    logic [NUM_W-1:0] r_num  [NUM_W];
    logic [NUM_W-1:0] r_quot [NUM_W];
    logic [DEN_W-1:0] r_rem  [NUM_W];
    logic [DEN_W-1:0] r_den  [NUM_W];
    logic             r_neg  [NUM_W];

    logic [NUM_W-1:0] n_num  [NUM_W];
    logic [NUM_W-1:0] n_quot [NUM_W];
    logic [DEN_W-1:0] n_rem  [NUM_W];
    logic [DEN_W-1:0] n_den  [NUM_W];
    logic             n_neg  [NUM_W];

    always_comb begin
        logic [NUM_W-1:0] p_num;
        logic [NUM_W-1:0] p_quot;
        logic [DEN_W-1:0] p_rem;
        logic [DEN_W-1:0] p_den;
        logic             p_neg;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   sub;
        logic             ge;
        for (int s = 0; s < NUM_W; s++) begin
            if (s == 0) begin
                p_num  = i_num;
                p_quot = '0;
                p_rem  = '0;
                p_den  = i_den;
                p_neg  = i_neg;
            end else begin
                p_num  = r_num[s-1];
                p_quot = r_quot[s-1];
                p_rem  = r_rem[s-1];
                p_den  = r_den[s-1];
                p_neg  = r_neg[s-1];
            end
            trial     = {p_rem, p_num[NUM_W-1]};
            sub       = trial - {1'b0, p_den};
            ge        = (trial >= {1'b0, p_den});
            n_rem[s]  = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
            n_num[s]  = {p_num[NUM_W-2:0], 1'b0};
            n_quot[s] = {p_quot[NUM_W-2:0], ge};
            n_den[s]  = p_den;
            n_neg[s]  = p_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NUM_W; s++) begin
                r_num[s]  <= n_num[s];
                r_quot[s] <= n_quot[s];
                r_rem[s]  <= n_rem[s];
                r_den[s]  <= n_den[s];
                r_neg[s]  <= n_neg[s];
            end
        end
    end

    assign o_quot = r_quot[NUM_W-1];
    assign o_neg  = r_neg[NUM_W-1];

endmodule

// ===== src/ray_box_slab_intersect.sv =====
// Ray versus axis-aligned box (slab test), Q16.16, fully pipelined top level.
// Depends on rbs_pkg and rbs_udiv.
//
// Takes one request per cycle while o_ready is high and returns one response
// per request, in order. The pipe holds one input
// register, one stage forming plane differences and magnitudes, 48 divider
// stages (one quotient bit each, six dividers side by side, two per axis),
// then sign fix-up, per-axis ordering, near/far reduction and the final
// register. The whole pipe advances on one enable that drops only when the
// two-entry output buffer (output register plus skid register) is full, so
// o_ready is a register output and a response waiting at the output does not
// stop new requests until the skid register is also occupied. Parallel axes
// (zero direction) are handled beside the dividers and never use their
// quotient. entry_distance is the near bound saturated to 31 bits, zero on
// a miss or when the origin is inside the box.
module ray_box_slab_intersect (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rbs_pkg::t_ray_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output rbs_pkg::t_ray_rsp o_rsp
);
    import rbs_pkg::*;

    logic w_en;

    // stage 0: input register
    t_ray_req r_req;
    logic     r_v0;

    // stage 1: differences and magnitudes
    logic signed [COORD_W-1:0] w_org  [NAXES];
    logic signed [COORD_W-1:0] w_dir  [NAXES];
    logic signed [COORD_W-1:0] w_bmin [NAXES];
    logic signed [COORD_W-1:0] w_bmax [NAXES];

    logic [NUM_W-1:0] n_num_lo [NAXES], r_num_lo [NAXES];
    logic [NUM_W-1:0] n_num_hi [NAXES], r_num_hi [NAXES];
    logic [DEN_W-1:0] n_den    [NAXES], r_den    [NAXES];
    logic             n_neg_lo [NAXES], r_neg_lo [NAXES];
    logic             n_neg_hi [NAXES], r_neg_hi [NAXES];
    logic [NAXES-1:0] n_par, r_par1;
    logic             n_miss, r_miss1;
    logic             r_v1;

    // sideband riding beside the dividers
    logic             r_sb_v    [NUM_W];
    logic [NAXES-1:0] r_sb_par  [NUM_W];
    logic             r_sb_miss [NUM_W];

    logic [NUM_W-1:0] w_q_lo [NAXES], w_q_hi [NAXES];
    logic             w_qn_lo [NAXES], w_qn_hi [NAXES];

    // stage 2: signed plane distances
    logic signed [T_W-1:0] r_t1 [NAXES], r_t2 [NAXES];
    logic [NAXES-1:0]      r_par2;
    logic                  r_miss2, r_v2;

    // stage 3: ordered per-axis interval
    logic signed [T_W-1:0] r_lo [NAXES], r_hi [NAXES];
    logic [NAXES-1:0]      r_hinf;
    logic                  r_miss3, r_v3;

    // stage 4: reduced interval
    logic signed [T_W-1:0] n_near, r_near, n_far, r_far;
    logic                  n_far_inf, r_far_inf;
    logic                  r_miss4, r_v4;

    t_ray_rsp n_rsp, r_out, r_skid;
    logic     r_out_v, r_skid_v;

    assign w_en    = !r_skid_v;
    assign o_ready = w_en;

    assign w_org  = '{r_req.origin_x,  r_req.origin_y,  r_req.origin_z};
    assign w_dir  = '{r_req.dir_x,     r_req.dir_y,     r_req.dir_z};
    assign w_bmin = '{r_req.box_min_x, r_req.box_min_y, r_req.box_min_z};
    assign w_bmax = '{r_req.box_max_x, r_req.box_max_y, r_req.box_max_z};

    always_comb begin
        logic signed [DIFF_W-1:0] d_lo;
        logic signed [DIFF_W-1:0] d_hi;
        logic        [DIFF_W-1:0] m_lo;
        logic        [DIFF_W-1:0] m_hi;
        n_miss = 1'b0;
        for (int a = 0; a < NAXES; a++) begin
            d_lo = {w_bmin[a][COORD_W-1], w_bmin[a]} - {w_org[a][COORD_W-1], w_org[a]};
            d_hi = {w_bmax[a][COORD_W-1], w_bmax[a]} - {w_org[a][COORD_W-1], w_org[a]};
            m_lo = d_lo[DIFF_W-1] ? -d_lo : d_lo;
            m_hi = d_hi[DIFF_W-1] ? -d_hi : d_hi;
            n_num_lo[a] = {m_lo[DIFF_W-2:0], {FRAC_W{1'b0}}};
            n_num_hi[a] = {m_hi[DIFF_W-2:0], {FRAC_W{1'b0}}};
            n_den[a]    = w_dir[a][COORD_W-1] ? -w_dir[a] : w_dir[a];
            n_neg_lo[a] = d_lo[DIFF_W-1] ^ w_dir[a][COORD_W-1];
            n_neg_hi[a] = d_hi[DIFF_W-1] ^ w_dir[a][COORD_W-1];
            n_par[a]    = (w_dir[a] == '0);
            // parallel and outside the slab: origin below min or above max
            if (n_par[a] && (d_lo > 0 || d_hi < 0)) begin
                n_miss = 1'b1;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NAXES; g++) begin : g_axis
            rbs_udiv u_div_lo (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_num  (r_num_lo[g]),
                .i_den  (r_den[g]),
                .i_neg  (r_neg_lo[g]),
                .o_quot (w_q_lo[g]),
                .o_neg  (w_qn_lo[g])
            );
            rbs_udiv u_div_hi (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_num  (r_num_hi[g]),
                .i_den  (r_den[g]),
                .i_neg  (r_neg_hi[g]),
                .o_quot (w_q_hi[g]),
                .o_neg  (w_qn_hi[g])
            );
        end
    endgenerate

    // near = max(0, lo), far = min(hi) with unbounded axes skipped
    always_comb begin
        logic signed [T_W-1:0] m01;
        logic signed [T_W-1:0] m2;
        logic signed [T_W-1:0] f01;
        logic                  f01_inf;
        m01 = (r_lo[0] > r_lo[1]) ? r_lo[0] : r_lo[1];
        m2  = (r_lo[2] > 0) ? r_lo[2] : '0;
        n_near = (m01 > m2) ? m01 : m2;
        if (r_hinf[0]) begin
            f01 = r_hi[1];
        end else if (r_hinf[1]) begin
            f01 = r_hi[0];
        end else begin
            f01 = (r_hi[0] < r_hi[1]) ? r_hi[0] : r_hi[1];
        end
        f01_inf = r_hinf[0] && r_hinf[1];
        if (f01_inf) begin
            n_far = r_hi[2];
        end else if (r_hinf[2]) begin
            n_far = f01;
        end else begin
            n_far = (f01 < r_hi[2]) ? f01 : r_hi[2];
        end
        n_far_inf = f01_inf && r_hinf[2];
    end

    always_comb begin
        logic hit;
        hit = !r_miss4 && (r_far_inf || (r_near <= r_far && r_far >= 0));
        n_rsp.hit = hit;
        if (!hit) begin
            n_rsp.entry_distance = '0;
        end else if (r_near[T_W-1:ENTRY_W] != '0) begin
            n_rsp.entry_distance = '1;
        end else begin
            n_rsp.entry_distance = r_near[ENTRY_W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req <= i_req;
            for (int a = 0; a < NAXES; a++) begin
                r_num_lo[a] <= n_num_lo[a];
                r_num_hi[a] <= n_num_hi[a];
                r_den[a]    <= n_den[a];
                r_neg_lo[a] <= n_neg_lo[a];
                r_neg_hi[a] <= n_neg_hi[a];
                r_t1[a] <= w_qn_lo[a] ? -$signed({1'b0, w_q_lo[a]})
                                      :  $signed({1'b0, w_q_lo[a]});
                r_t2[a] <= w_qn_hi[a] ? -$signed({1'b0, w_q_hi[a]})
                                      :  $signed({1'b0, w_q_hi[a]});
                if (r_par2[a]) begin
                    r_lo[a] <= '0;
                    r_hi[a] <= '0;
                end else if (r_t1[a] > r_t2[a]) begin
                    r_lo[a] <= r_t2[a];
                    r_hi[a] <= r_t1[a];
                end else begin
                    r_lo[a] <= r_t1[a];
                    r_hi[a] <= r_t2[a];
                end
            end
            r_par1  <= n_par;
            r_miss1 <= n_miss;
            r_sb_par[0]  <= r_par1;
            r_sb_miss[0] <= r_miss1;
            for (int s = 1; s < NUM_W; s++) begin
                r_sb_par[s]  <= r_sb_par[s-1];
                r_sb_miss[s] <= r_sb_miss[s-1];
            end
            r_par2    <= r_sb_par[NUM_W-1];
            r_miss2   <= r_sb_miss[NUM_W-1];
            r_hinf    <= r_par2;
            r_miss3   <= r_miss2;
            r_near    <= n_near;
            r_far     <= n_far;
            r_far_inf <= n_far_inf;
            r_miss4   <= r_miss3;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            for (int s = 0; s < NUM_W; s++) begin
                r_sb_v[s] <= 1'b0;
            end
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_sb_v[0] <= r_v1;
            for (int s = 1; s < NUM_W; s++) begin
                r_sb_v[s] <= r_sb_v[s-1];
            end
            r_v2 <= r_sb_v[NUM_W-1];
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // output register plus skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_out_v && i_ready) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_en && r_v4;
                r_out   <= n_rsp;
            end
        end else if (!r_out_v) begin
            r_out_v <= w_en && r_v4;
            r_out   <= n_rsp;
        end else if (w_en && r_v4) begin
            r_skid   <= n_rsp;
            r_skid_v <= 1'b1;
        end
    end

    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

endmodule

// ===== tb/testbench.sv =====
// Testbench for ray_box_slab_intersect: slab-test predictor in a small scoreboard
// class, random valid/ready idling on both sides. Depends on rbs_pkg and the RTL in src.
`timescale 1ns / 100ps

module testbench;
    import rbs_pkg::*;

    // Expected responses, predicted from each accepted request.
    class slab_scoreboard;
        t_ray_rsp pending[$];
        int       n_mismatch;

        // One axis: returns 0 when the axis rejects the ray, else narrows near/far.
        function bit narrow(longint org, longint dir, longint bmin,
                            longint bmax, ref longint near_t,
                            ref longint far_t);
            longint t1, t2, s;
            if (dir == 0)
                return !(org < bmin || org > bmax);
            t1 = ((bmin - org) * 65536) / dir;
            t2 = ((bmax - org) * 65536) / dir;
            if (t1 > t2) begin
                s = t1; t1 = t2; t2 = s;
            end
            if (t1 > near_t) near_t = t1;
            if (t2 < far_t)  far_t = t2;
            return 1;
        endfunction

        function void note_request(t_ray_req r);
            longint   org[3], dir[3], bmin[3], bmax[3];
            longint   near_t, far_t;
            bit       ok;
            t_ray_rsp e;
            org  = '{longint'(r.origin_x), longint'(r.origin_y), longint'(r.origin_z)};
            dir  = '{longint'(r.dir_x), longint'(r.dir_y), longint'(r.dir_z)};
            bmin = '{longint'(r.box_min_x), longint'(r.box_min_y), longint'(r.box_min_z)};
            bmax = '{longint'(r.box_max_x), longint'(r.box_max_y), longint'(r.box_max_z)};
            near_t = 0;
            far_t  = 64'h7FFF_FFFF_FFFF_FFFF;
            ok = 1;
            for (int a = 0; a < 3 && ok; a++) begin
                ok = narrow(org[a], dir[a], bmin[a], bmax[a], near_t, far_t);
                if (ok && (near_t > far_t || far_t < 0)) ok = 0;
            end
            e = '0;
            if (ok) begin
                e.hit = 1'b1;
                e.entry_distance = (near_t > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF
                                                              : near_t[30:0];
            end
            pending.push_back(e);
        endfunction

        function void check_response(t_ray_rsp got);
            t_ray_rsp e;
            if (pending.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected response %p", got);
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit || got.entry_distance !== e.entry_distance) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: exp hit=%0d t=%h got hit=%0d t=%h",
                             e.hit, e.entry_distance, got.hit, got.entry_distance);
            end
        endfunction
    endclass

    localparam int LATENCY = 53;

    logic     clk, rst_n;
    logic     in_valid, in_ready, out_valid, out_ready;
    t_ray_req req;
    t_ray_rsp rsp;

    slab_scoreboard sb;
    bit       hold_rx;      // long receiver hold-off, own process
    bit       no_idle;      // stretch with no gaps on either side

    ray_box_slab_intersect u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_req(req),
        .o_valid(out_valid), .i_ready(out_ready), .o_rsp(rsp)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: bounds the slowest run, 700 requests with random gaps on both sides plus hold-offs.
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Monitor: both handshakes sampled at the rising edge.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) sb.note_request(req);
        if (rst_n && out_valid && out_ready) sb.check_response(rsp);
    end

    // Receiver: random stalls per response, plus an external hold-off.
    initial begin
        int gap;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap != 0 || hold_rx) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_rx) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk iff out_valid);
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return $urandom;
            default: return $signed($urandom_range(0, 32'h0014_0000)) - 32'sh000A_0000;
        endcase
    endfunction

    // Mostly well-formed boxes (min <= max) near the origin, with ray aimed around.
    function automatic t_ray_req rand_request();
        t_ray_req r;
        logic signed [31:0] a, b;
        r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
        r.dir_x = ($urandom_range(0, 4) == 0) ? 32'h0 : rand_coord();
        r.dir_y = ($urandom_range(0, 4) == 0) ? 32'h0 : rand_coord();
        r.dir_z = ($urandom_range(0, 4) == 0) ? 32'h0 : rand_coord();
        for (int k = 0; k < 3; k++) begin
            a = rand_coord(); b = rand_coord();
            if ($urandom_range(0, 9) != 0 && a > b) begin
                logic signed [31:0] s;
                s = a; a = b; b = s;
            end
            case (k)
                0: begin r.box_min_x = a; r.box_max_x = b; end
                1: begin r.box_min_y = a; r.box_max_y = b; end
                default: begin r.box_min_z = a; r.box_max_z = b; end
            endcase
        end
        return r;
    endfunction

    task automatic send_request(t_ray_req r, bit allow_gap);
        int gap;
        gap = (allow_gap && !no_idle) ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req      <= r;
        @(posedge clk iff in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic t_ray_req unit_ray(logic [31:0] dx, logic [31:0] dy,
                                          logic [31:0] dz);
        t_ray_req r;
        r = '0;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.box_min_x = 32'h0001_0000; r.box_max_x = 32'h0002_0000;
        r.box_min_y = 32'hFFFF_0000; r.box_max_y = 32'h0001_0000;
        r.box_min_z = 32'hFFFF_0000; r.box_max_z = 32'h0001_0000;
        return r;
    endfunction

    initial begin
        t_ray_req r;
        sb = new();
        in_valid = 1'b0;
        req = '0;
        hold_rx = 1'b0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain hit ahead, miss behind, all-parallel inside/outside,
        // inverted boxes, saturated entry, field extremes.
        send_request(unit_ray(32'h0001_0000, 0, 0), 1);
        send_request(unit_ray(32'hFFFF_0000, 0, 0), 1);
        r = unit_ray(0, 0, 0); r.box_min_x = 32'hFFFF_0000;
        send_request(r, 1);                               // parallel, inside
        send_request(unit_ray(0, 0, 0), 1);               // parallel, outside
        r = unit_ray(0, 0, 0); r.box_min_x = 32'h0003_0000;
        send_request(r, 1);                               // parallel, inverted slab
        r = unit_ray(32'h0001_0000, 0, 0);
        r.box_min_x = 32'h0003_0000;
        send_request(r, 1);                               // inverted box, ray along
        r = unit_ray(32'h0000_0001, 0, 0);
        r.box_min_x = 32'h7FFF_0000; r.box_max_x = 32'h7FFF_FFFF;
        send_request(r, 1);                               // huge entry, saturates
        r = unit_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        r.origin_x = 32'h7FFF_FFFF; r.origin_y = 32'h8000_0000;
        send_request(r, 1);
        r = '1;
        send_request(r, 1);
        r = '0;
        send_request(r, 1);
        r = '0; r.box_min_x = 32'h8000_0000; r.box_min_y = 32'h8000_0000;
        r.box_min_z = 32'h8000_0000; r.box_max_x = 32'h7FFF_FFFF;
        r.box_max_y = 32'h7FFF_FFFF; r.box_max_z = 32'h7FFF_FFFF;
        r.dir_x = 32'h8000_0000; r.origin_x = 32'h7FFF_FFFF;
        send_request(r, 1);
        r.dir_x = 32'h7FFF_FFFF; r.origin_x = 32'h8000_0000;
        send_request(r, 1);
        r = unit_ray(32'h0001_0000, 32'h0000_8000, 32'hFFFF_C000);
        r.origin_x = 32'hFFFB_0000;
        send_request(r, 1);                               // diagonal miss
        wait_drained();

        for (int i = 0; i < 700; i++) begin
            if (i == 150) begin
                // Receiver holds off long enough to fill the pipe and stall input.
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (200) @(posedge clk);
                        hold_rx = 1'b0;
                    end
                join_none
                no_idle = 1'b1;
            end
            if (i == 260) no_idle = 1'b0;
            if (i == 400) wait_drained();                 // sender pause
            if (i == 500) no_idle = 1'b1;
            if (i == 600) no_idle = 1'b0;
            send_request(rand_request(), 1);
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.n_mismatch == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
